// ===== design/pfd_pkg.sv =====
// Shared types, constants and helpers for the filtered-derivative PID block.
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned KpW    = 26;
  localparam int unsigned IgW    = 26;
  localparam int unsigned PoleW  = 16;
  localparam int unsigned DgW    = 28;
  localparam int unsigned AngleW = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned DiffW  = 18;
  localparam int unsigned TermW  = 40;
  localparam int unsigned PropW  = 44;
  localparam int unsigned DriveW = 16;

  // Register indexes on the configuration channel.
  localparam logic [CfgIdxW-1:0] CfgIdxKp    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxInt   = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxPole  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxDgain = 8'd3;

  localparam logic [KpW-1:0]   KpReset    = 26'd6619136;
  localparam logic [IgW-1:0]   IntReset   = 26'd902611;
  localparam logic [PoleW-1:0] PoleReset  = 16'd5503;
  localparam logic [DgW-1:0]   DgainReset = 28'd11116216;

  localparam logic signed [TermW-1:0] TermMax = {1'b0, {(TermW-1){1'b1}}};
  localparam logic signed [TermW-1:0] TermMin = {1'b1, {(TermW-1){1'b0}}};

  typedef struct packed {
    logic [KpW-1:0]   kp_gain;
    logic [IgW-1:0]   int_gain;
    logic [PoleW-1:0] der_pole;
    logic [DgW-1:0]   der_gain;
  } cfg_t;

  // One sample's three terms, handed from the term pipeline to the output stage.
  typedef struct packed {
    logic                     valid;
    logic signed [PropW-1:0]  prop;
    logic signed [TermW-1:0]  integ;
    logic signed [TermW-1:0]  deriv;
  } terms_t;

  // Clamp a 48-bit sum to the signed 40-bit term range.
  function automatic logic signed [TermW-1:0] sat_term(input logic signed [47:0] x);
    logic signed [TermW-1:0] res;
    if (x[47:TermW-1] != {(48-TermW+1){x[47]}}) begin
      res = x[47] ? TermMin : TermMax;
    end else begin
      res = x[TermW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/pfd_cfg_regs.sv =====
// Gain and pole registers written over the configuration channel.
`timescale 1ns / 1ps
`default_nettype none

module pfd_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pfd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pfd_pkg::CfgDataW-1:0]  cfg_data_i,
  output pfd_pkg::cfg_t                      cfg_o
);

  pfd_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain  <= pfd_pkg::KpReset;
      cfg_q.int_gain <= pfd_pkg::IntReset;
      cfg_q.der_pole <= pfd_pkg::PoleReset;
      cfg_q.der_gain <= pfd_pkg::DgainReset;
    end else if (cfg_valid_i) begin
      // Unknown indexes are dropped.
      case (cfg_index_i)
        pfd_pkg::CfgIdxKp:    cfg_q.kp_gain  <= cfg_data_i[pfd_pkg::KpW-1:0];
        pfd_pkg::CfgIdxInt:   cfg_q.int_gain <= cfg_data_i[pfd_pkg::IgW-1:0];
        pfd_pkg::CfgIdxPole:  cfg_q.der_pole <= cfg_data_i[pfd_pkg::PoleW-1:0];
        pfd_pkg::CfgIdxDgain: cfg_q.der_gain <= cfg_data_i[pfd_pkg::DgW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/pfd_terms.sv =====
// Error, products and the integral and derivative recurrences, three registered stages.
`timescale 1ns / 1ps
`default_nettype none

module pfd_terms (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                adv_i,
  input  wire logic                                in_valid_i,
  input  wire logic signed [pfd_pkg::AngleW-1:0]   reference_angle_i,
  input  wire logic signed [pfd_pkg::AngleW-1:0]   measured_angle_i,
  input  wire logic                                start_run_i,
  input  pfd_pkg::cfg_t                            cfg_i,
  output pfd_pkg::terms_t                          terms_o
);

  localparam int unsigned IpW = 44;
  localparam int unsigned DgProdW = 47;

  logic accept;
  logic signed [pfd_pkg::ErrW-1:0]  err_in;
  logic signed [pfd_pkg::ErrW-1:0]  prev_sel;
  logic signed [pfd_pkg::DiffW-1:0] diff_in;
  logic signed [pfd_pkg::ErrW-1:0]  last_err_q;

  logic                             v1_q, start1_q;
  logic signed [pfd_pkg::ErrW-1:0]  err1_q, prev1_q;
  logic signed [pfd_pkg::DiffW-1:0] diff1_q;

  logic                             v2_q, start2_q;
  logic signed [pfd_pkg::PropW-1:0] prop_d, prop2_q;
  logic signed [IpW-1:0]            ip_d, ip2_q;
  logic signed [DgProdW-1:0]        dg_d, dg2_q;

  logic                             v3_q;
  logic signed [pfd_pkg::PropW-1:0] prop3_q;
  logic signed [pfd_pkg::TermW-1:0] integ_q, deriv_q, integ_d, deriv_d;
  logic signed [pfd_pkg::TermW-1:0] integ_base, deriv_base;
  logic signed [56:0]               pole_prod, pole_rnd;
  logic signed [40:0]               pole_term;
  logic signed [47:0]               integ_sum, deriv_sum;

  assign accept   = in_valid_i && adv_i;
  assign err_in   = {reference_angle_i[pfd_pkg::AngleW-1], reference_angle_i}
                  - {measured_angle_i[pfd_pkg::AngleW-1], measured_angle_i};
  // A new run takes its error difference against zero.
  assign prev_sel = start_run_i ? '0 : last_err_q;
  assign diff_in  = {err_in[pfd_pkg::ErrW-1], err_in} - {prev_sel[pfd_pkg::ErrW-1], prev_sel};

  assign prop_d = $signed({1'b0, cfg_i.kp_gain}) * err1_q;
  assign ip_d   = $signed({1'b0, cfg_i.int_gain}) * prev1_q;
  assign dg_d   = $signed({1'b0, cfg_i.der_gain}) * diff1_q;

  assign integ_base = start2_q ? '0 : integ_q;
  assign deriv_base = start2_q ? '0 : deriv_q;
  assign pole_prod  = $signed({1'b0, cfg_i.der_pole}) * deriv_base;
  // Round half up, then floor by the 16 fraction bits of the pole.
  assign pole_rnd   = pole_prod + 57'sd32768;
  assign pole_term  = pole_rnd[56:16];
  assign integ_sum  = {{8{integ_base[pfd_pkg::TermW-1]}}, integ_base}
                    + {{4{ip2_q[IpW-1]}}, ip2_q};
  assign deriv_sum  = {{7{pole_term[40]}}, pole_term}
                    + {dg2_q[DgProdW-1], dg2_q};
  assign integ_d    = pfd_pkg::sat_term(integ_sum);
  assign deriv_d    = pfd_pkg::sat_term(deriv_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      last_err_q <= '0;
      integ_q    <= '0;
      deriv_q    <= '0;
    end else if (adv_i) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (accept) begin
        last_err_q <= err_in;
      end
      if (v2_q) begin
        integ_q <= integ_d;
        deriv_q <= deriv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (accept) begin
        err1_q   <= err_in;
        prev1_q  <= prev_sel;
        diff1_q  <= diff_in;
        start1_q <= start_run_i;
      end
      if (v1_q) begin
        prop2_q  <= prop_d;
        ip2_q    <= ip_d;
        dg2_q    <= dg_d;
        start2_q <= start1_q;
      end
      if (v2_q) begin
        prop3_q <= prop2_q;
      end
    end
  end

  assign terms_o.valid = v3_q;
  assign terms_o.prop  = prop3_q;
  assign terms_o.integ = integ_q;
  assign terms_o.deriv = deriv_q;

  // The stored terms only move when a word passes through the recurrence stage.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv_i && v2_q) |=> $stable(integ_q) && $stable(deriv_q))
    else $error("stored terms changed without a word in the recurrence stage");

  a_err_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(last_err_q))
    else $error("previous error changed without an accepted word");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && v1_q) |=> v2_q)
    else $error("word lost between the error and product stages");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(v1_q) && $stable(v2_q) && $stable(v3_q))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== design/pfd_out_stage.sv =====
// Sum of the terms, rounding to Q5.11, clipping and the result register.
`timescale 1ns / 1ps
`default_nettype none

module pfd_out_stage (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  pfd_pkg::terms_t                        terms_i,
  output logic                                   adv_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [pfd_pkg::DriveW-1:0]      drive_value_o,
  output logic                                   drive_saturated_o
);

  logic                               out_valid_q;
  logic signed [pfd_pkg::DriveW-1:0]  drive_q, drive_d;
  logic                               sat_q, sat_d;
  logic signed [45:0]                 sum, sum_rnd;
  logic signed [28:0]                 scaled;

  // The whole pipeline moves when the result register is free or being emptied.
  assign adv_o = !out_valid_q || out_ready_i;

  assign sum     = {{2{terms_i.prop[pfd_pkg::PropW-1]}}, terms_i.prop}
                 + {{6{terms_i.integ[pfd_pkg::TermW-1]}}, terms_i.integ}
                 + {{6{terms_i.deriv[pfd_pkg::TermW-1]}}, terms_i.deriv};
  assign sum_rnd = sum + 46'sd65536;
  assign scaled  = sum_rnd[45:17];

  always_comb begin
    if (scaled[28:pfd_pkg::DriveW-1] != {(29-pfd_pkg::DriveW+1){scaled[28]}}) begin
      sat_d   = 1'b1;
      drive_d = scaled[28] ? {1'b1, {(pfd_pkg::DriveW-1){1'b0}}}
                           : {1'b0, {(pfd_pkg::DriveW-1){1'b1}}};
    end else begin
      sat_d   = 1'b0;
      drive_d = scaled[pfd_pkg::DriveW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= terms_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && terms_i.valid) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_value_o     = drive_q;
  assign drive_saturated_o = sat_q;

  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sat_q) |-> (drive_q == 16'sh7FFF || drive_q == 16'sh8000))
    else $error("saturation flag set with the drive off the rails");

  a_valid_from_terms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_o && terms_i.valid) |=> out_valid_q)
    else $error("finished terms did not reach the result register");

endmodule

`default_nettype wire

// ===== design/pid_filtered_derivative_top.sv =====
// Top level of the PID controller with filtered derivative.
// A word passes the error, product and recurrence stages and then the result register.
// Throughput: one word per cycle when not stalled; the integral and derivative recurrences
// close in one stage (pole multiply, add and clamp), which sets the clock.
// Backpressure stalls the whole pipeline; a new word is taken while the result waits if it drains.
// Reset (asynchronous, active low) empties the pipeline, zeroes the stored
// error and terms and loads the default gains.
`timescale 1ns / 1ps
`default_nettype none

module pid_filtered_derivative_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [15:0] reference_angle, [31:16] measured_angle
  input  wire logic [31:0]                   s_axis_tdata_i,
  // [0] start_run
  input  wire logic [0:0]                    s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [15:0] drive_value
  output logic [15:0]                        m_axis_tdata_o,
  // [0] drive_saturated
  output logic [0:0]                         m_axis_tuser_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pfd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pfd_pkg::CfgDataW-1:0]  cfg_data_i
);

  pfd_pkg::cfg_t   cfg;
  pfd_pkg::terms_t terms;
  logic            adv;
  logic signed [pfd_pkg::DriveW-1:0] drive_value;
  logic            drive_saturated;

  pfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pfd_terms u_terms (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .in_valid_i        (s_axis_tvalid_i),
    .reference_angle_i ($signed(s_axis_tdata_i[15:0])),
    .measured_angle_i  ($signed(s_axis_tdata_i[31:16])),
    .start_run_i       (s_axis_tuser_i[0]),
    .cfg_i             (cfg),
    .terms_o           (terms)
  );

  pfd_out_stage u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .terms_i           (terms),
    .adv_o             (adv),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .drive_value_o     (drive_value),
    .drive_saturated_o (drive_saturated)
  );

  assign s_axis_tready_o   = adv;
  assign m_axis_tdata_o    = drive_value;
  assign m_axis_tuser_o[0] = drive_saturated;

endmodule

`default_nettype wire

// ===== tb/sv/pfd_drive_checker.sv =====
// Checker that predicts every drive word of the filtered-derivative PID block and compares it.
`timescale 1ns / 1ps

module pfd_drive_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  // [15:0] reference_angle, [31:16] measured_angle
  input  logic [31:0]                  s_tdata_i,
  // [0] start_run
  input  logic [0:0]                   s_tuser_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  // [15:0] drive_value
  input  logic [15:0]                  m_tdata_i,
  // [0] drive_saturated
  input  logic [0:0]                   m_tuser_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [pfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pfd_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           mismatches_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           clipped_o
);

  typedef struct packed {
    logic [15:0] value;
    logic        clipped;
  } drive_t;

  localparam longint TermHi = 64'sd549755813887;
  localparam longint TermLo = -TermHi - 64'sd1;

  logic [pfd_pkg::KpW-1:0]   kp_r;
  logic [pfd_pkg::IgW-1:0]   ig_r;
  logic [pfd_pkg::PoleW-1:0] pole_r;
  logic [pfd_pkg::DgW-1:0]   dg_r;

  // Loop state in units of 2^-28 V, the error in Q5.12.
  longint prev_err;
  longint integ_acc;
  longint deriv_acc;

  drive_t drive_expected_q[$];
  int     n_mismatch;
  int     n_checked;
  int     n_clipped;

  function automatic longint clamp_term(input longint x);
    if (x > TermHi) return TermHi;
    if (x < TermLo) return TermLo;
    return x;
  endfunction

  task automatic predict_drive(input logic [31:0] data, input logic start, output drive_t res);
    longint err;
    longint integ;
    longint deriv;
    longint total;
    longint volts;
    if (start) begin
      prev_err  = 0;
      integ_acc = 0;
      deriv_acc = 0;
    end
    err   = longint'($signed(data[15:0])) - longint'($signed(data[31:16]));
    integ = clamp_term(integ_acc + longint'(ig_r) * prev_err);
    // The pole product is rounded half up back to 28 fraction bits.
    deriv = (longint'(pole_r) * deriv_acc + 64'sd32768) >>> 16;
    deriv = clamp_term(deriv + longint'(dg_r) * (err - prev_err));
    total = longint'(kp_r) * err + integ + deriv;
    volts = (total + 64'sd65536) >>> 17;
    res.clipped = 1'b0;
    if (volts > 64'sd32767) begin
      volts       = 64'sd32767;
      res.clipped = 1'b1;
    end else if (volts < -64'sd32768) begin
      volts       = -64'sd32768;
      res.clipped = 1'b1;
    end
    res.value = volts[15:0];
    prev_err  = err;
    integ_acc = integ;
    deriv_acc = deriv;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drive_t predicted;
    if (!rst_ni) begin
      kp_r       = pfd_pkg::KpReset;
      ig_r       = pfd_pkg::IntReset;
      pole_r     = pfd_pkg::PoleReset;
      dg_r       = pfd_pkg::DgainReset;
      prev_err   = 0;
      integ_acc  = 0;
      deriv_acc  = 0;
      n_mismatch = 0;
      n_checked  = 0;
      n_clipped  = 0;
      drive_expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pfd_pkg::CfgIdxKp:    kp_r   = cfg_data_i[pfd_pkg::KpW-1:0];
          pfd_pkg::CfgIdxInt:   ig_r   = cfg_data_i[pfd_pkg::IgW-1:0];
          pfd_pkg::CfgIdxPole:  pole_r = cfg_data_i[pfd_pkg::PoleW-1:0];
          pfd_pkg::CfgIdxDgain: dg_r   = cfg_data_i[pfd_pkg::DgW-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (drive_expected_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("%0t: drive word %0d (clipped %0b) arrived with nothing expected",
                     $time, $signed(m_tdata_i), m_tuser_i[0]);
          end
        end else begin
          predicted = drive_expected_q.pop_front();
          n_checked++;
          if (predicted.clipped) n_clipped++;
          if (m_tdata_i !== predicted.value || m_tuser_i[0] !== predicted.clipped) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("%0t: drive word %0d: value exp %0d got %0d, clipped exp %0b got %0b",
                       $time, n_checked, $signed(predicted.value), $signed(m_tdata_i),
                       predicted.clipped, m_tuser_i[0]);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_drive(s_tdata_i, s_tuser_i[0], predicted);
        drive_expected_q.push_back(predicted);
      end
    end
    mismatches_o <= n_mismatch;
    pending_o    <= drive_expected_q.size();
    checked_o    <= n_checked;
    clipped_o    <= n_clipped;
  end

endmodule

// ===== tb/sv/tb_pid_filtered_derivative_top.sv =====
// Testbench top for the filtered-derivative PID block: stimulus, gain settings and verdict.
`timescale 1ns / 1ps

module tb_pid_filtered_derivative_top;

  localparam int unsigned RunLimitNs = 5_000_000;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [31:0]                  s_tdata   = '0;
  logic [0:0]                   s_tuser   = '0;
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [15:0]                  m_tdata;
  logic [0:0]                   m_tuser;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [pfd_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [pfd_pkg::CfgDataW-1:0] cfg_data  = '0;

  int mismatches;
  int pending;
  int checked;
  int clipped;

  int n_samples  = 0;
  int n_starts   = 0;
  int n_settings = 0;
  bit tx_quiet   = 1'b0;

  always #5 clk = ~clk;

  pid_filtered_derivative_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  pfd_drive_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .clipped_o    (clipped)
  );

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Leaves cfg_valid high so that back-to-back writes need no gap.
  task automatic write_reg(input logic [pfd_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_gains(input logic [31:0] kp, input logic [31:0] ig,
                               input logic [31:0] pole, input logic [31:0] dg);
    logic [31:0] pick;
    if ($urandom_range(0, 2) == 0) begin
      pick = $urandom_range(pfd_pkg::CfgIdxDgain + 1, (1 << pfd_pkg::CfgIdxW) - 1);
      write_reg(pick[pfd_pkg::CfgIdxW-1:0], $urandom());
    end
    write_reg(pfd_pkg::CfgIdxKp, kp);
    write_reg(pfd_pkg::CfgIdxInt, ig);
    write_reg(pfd_pkg::CfgIdxPole, pole);
    write_reg(pfd_pkg::CfgIdxDgain, dg);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Valid stays high after the handshake, so a zero gap sends the next word straight away.
  task automatic send_sample(input logic signed [15:0] tgt, input logic signed [15:0] meas,
                             input logic start);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {meas, tgt};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    n_samples++;
    if (start) n_starts++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // A closed-loop looking run: a set-point with occasional steps, the angle chasing it.
  task automatic run_sequence(input int len);
    int tgt;
    int meas;
    int span;
    int i;
    span = ($urandom_range(0, 1) == 0) ? 8192 : 32768;
    tgt  = int'($urandom_range(0, 2 * span - 1)) - span;
    meas = int'($urandom_range(0, 2 * span - 1)) - span;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) tgt = int'($urandom_range(0, 2 * span - 1)) - span;
      send_sample(clip16(tgt), clip16(meas), i == 0);
      meas = meas + (tgt - meas) / 4 + int'($urandom_range(0, 64)) - 32;
    end
  endtask

  task automatic noise_burst(input int len);
    logic [31:0] word;
    int i;
    for (i = 0; i < len; i++) begin
      word = $urandom();
      send_sample(word[15:0], word[31:16], $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin : stimulus
    int phase;
    int goal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default gains: largest errors both ways, a restart mid-run and a settling ramp.
    send_sample(16'sd0, 16'sd0, 1'b1);
    send_sample(16'sh7FFF, 16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 16'sh8000, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b1);
    send_sample(16'sd4096, 16'sd0, 1'b0);
    send_sample(16'sd4096, 16'sd2048, 1'b0);
    send_sample(16'sd4096, 16'sd4096, 1'b0);
    wait_drained();

    // All gains at full scale drive both stored terms into their 40-bit limits.
    write_reg({pfd_pkg::CfgIdxW{1'b1}}, 32'h0000_0001);
    program_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(16'sh7FFF, 16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 16'sh8000, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0);
    wait_drained();

    program_gains(32'd0, 32'd0, 32'd0, 32'd0);
    send_sample(16'sh7FFF, 16'sh8000, 1'b1);
    send_sample(16'sh8000, 16'sh7FFF, 1'b0);
    wait_drained();

    // Derivative alone with the slowest pole: a unit error pulse, a decaying tail and a unit error of the other sign.
    program_gains(32'd0, 32'd0, 32'h0000_FFFF, 32'h0FFF_FFFF);
    send_sample(16'sd1, 16'sd0, 1'b1);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd1, 1'b0);

    for (phase = 0; phase < 7; phase++) begin
      wait_drained();
      case (phase)
        0: program_gains({6'd0, pfd_pkg::KpReset}, {6'd0, pfd_pkg::IntReset},
                         {16'd0, pfd_pkg::PoleReset}, {4'd0, pfd_pkg::DgainReset});
        1: program_gains($urandom_range(0, 1 << 22), $urandom_range(0, 1 << 18),
                         $urandom_range(0, 65535), $urandom_range(0, 1 << 22));
        2: program_gains($urandom(), $urandom(), $urandom(), $urandom());
        3: program_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: program_gains($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 16),
                         $urandom_range(60000, 65535), $urandom_range(0, 1 << 24));
        5: program_gains($urandom(), $urandom(), $urandom(), $urandom());
        default: program_gains(32'd0, $urandom_range(0, 1 << 20), 32'h0000_FFFF, $urandom());
      endcase
      tx_quiet = (phase == 3) || ($urandom_range(0, 3) == 0);
      goal = n_samples + 150;
      while (n_samples < goal) begin
        if ($urandom_range(0, 3) != 0) run_sequence($urandom_range(4, 40));
        else noise_burst($urandom_range(1, 8));
        if ($urandom_range(0, 30) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Drove %0d samples (%0d run starts) over %0d gain settings.",
             n_samples, n_starts, n_settings);
    $display("Checked %0d drive words, %0d of them clipped to range.", checked, clipped);
    if (mismatches == 0 && pending == 0) begin
      $display("[pid_filtered_derivative_top] OK");
    end else begin
      $display("[pid_filtered_derivative_top] ERROR");
    end
    $finish;
  end

  // The receiving side stalls at random, with quiet stretches now and then.
  initial begin : drive_sink
    int gap;
    int stretch;
    bit quiet;
    stretch = 0;
    quiet   = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(20, 150);
        quiet   = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : run_limit
    #(RunLimitNs);
    $display("[pid_filtered_derivative_top] ERROR");
    $finish;
  end

endmodule
